FILE: rtl/core/spsil_pkg.sv
package spsil_pkg;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_REG   = 2'd1,
    ACT_DRAIN = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    STAT_DONE    = 3'd0,
    STAT_OTHER   = 3'd1,
    STAT_INVALID = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_ENTRY   = 3'd4,
    STAT_EMPTY   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PSEL_ZERO = 2'd0,
    PSEL_ITEM = 2'd1,
    PSEL_CELL = 2'd2
  } prio_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_PROD,
    S_SUM,
    S_INS,
    S_EMIT,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic      capture;
    logic      clear;
    logic      prod;
    logic      sum;
    logic      insert;
    logic      drain_start;
    logic      rotate;
    logic      load_out;
    status_t   status;
    prio_sel_t prio_sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    layer_valid;
    logic    proc_match;
    logic    full;
    logic    empty;
    logic    drain_last;
    logic    can_load;
  } dp_stat_t;

  localparam int PRIO_BITS = 32;
  localparam int STEP_BITS = 16;

endpackage

FILE: rtl/core/spsil_ctrl.sv
module spsil_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  spsil_pkg::dp_stat_t stat,
  output spsil_pkg::dp_cmd_t  cmd
);
  import spsil_pkg::*;

  state_t  state, state_next;
  status_t emit_status, emit_status_next;
  logic    emit_prio, emit_prio_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      emit_status <= STAT_DONE;
      emit_prio   <= 1'b0;
    end else begin
      state       <= state_next;
      emit_status <= emit_status_next;
      emit_prio   <= emit_prio_next;
    end
  end

  always_comb begin
    cmd              = '0;
    cmd.status       = STAT_DONE;
    cmd.prio_sel     = PSEL_ZERO;
    state_next       = state;
    emit_status_next = emit_status;
    emit_prio_next   = emit_prio;
    s_tready         = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        emit_prio_next   = 1'b0;
        emit_status_next = STAT_DONE;
        state_next       = S_EMIT;
        unique case (stat.action)
          ACT_BEGIN: cmd.clear = 1'b1;
          ACT_REG: begin
            if (!stat.layer_valid) begin
              emit_status_next = STAT_INVALID;
            end else if (!stat.proc_match) begin
              emit_status_next = STAT_OTHER;
            end else begin
              state_next = S_PROD;
            end
          end
          ACT_DRAIN: begin
            if (stat.empty) begin
              emit_status_next = STAT_EMPTY;
            end else begin
              cmd.drain_start = 1'b1;
              state_next      = S_DRAIN;
            end
          end
          default: ;
        endcase
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_INS;
      end
      S_INS: begin
        cmd.insert       = !stat.full;
        emit_prio_next   = 1'b1;
        emit_status_next = stat.full ? STAT_FULL : STAT_DONE;
        state_next       = S_EMIT;
      end
      S_EMIT: begin
        if (stat.can_load) begin
          cmd.load_out = 1'b1;
          cmd.status   = emit_status;
          cmd.prio_sel = emit_prio ? PSEL_ITEM : PSEL_ZERO;
          cmd.last     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (stat.can_load) begin
          cmd.load_out = 1'b1;
          cmd.rotate   = 1'b1;
          cmd.status   = STAT_ENTRY;
          cmd.prio_sel = PSEL_CELL;
          cmd.last     = stat.drain_last;
          if (stat.drain_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/spsil_dp.sv
module spsil_dp #(
  parameter int CAPACITY = 32,
  parameter int TAG_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  spsil_pkg::dp_cmd_t                  cmd,
  output spsil_pkg::dp_stat_t                 stat,
  input  logic [1:0]                          in_action,
  input  logic [2:0]                          in_process,
  input  logic [TAG_BITS-1:0]                 in_tag,
  input  logic                                in_layer_valid,
  input  logic [5:0]                          in_layer,
  input  logic signed [7:0]                   in_offset,
  input  logic signed [15:0]                  in_adjust,
  input  logic [spsil_pkg::STEP_BITS-1:0]     layer_step,
  input  logic [spsil_pkg::STEP_BITS-1:0]     offset_step,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output spsil_pkg::status_t                  out_status,
  output logic [TAG_BITS-1:0]                 out_tag,
  output logic signed [spsil_pkg::PRIO_BITS-1:0] out_prio,
  output logic                                out_last
);
  import spsil_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [1:0]                  item_action;
  logic [2:0]                  item_process;
  logic [TAG_BITS-1:0]         item_tag;
  logic                        item_valid;
  logic [5:0]                  item_layer;
  logic signed [7:0]           item_offset;
  logic signed [15:0]          item_adjust;
  logic [21:0]                 prod_layer;
  logic signed [24:0]          prod_off;
  logic signed [PRIO_BITS-1:0] item_prio;

  logic [2:0]    cur_proc;
  logic [CW-1:0] count;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] remaining;

  logic [TAG_BITS-1:0]         cell_tag  [CAPACITY];
  logic signed [PRIO_BITS-1:0] cell_prio [CAPACITY];
  logic [CAPACITY-1:0]         lower;

  assign count_m1 = count - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_action  <= in_action;
      item_process <= in_process;
      item_tag     <= in_tag;
      item_valid   <= in_layer_valid;
      item_layer   <= in_layer;
      item_offset  <= in_offset;
      item_adjust  <= in_adjust;
    end
    if (cmd.prod) begin
      prod_layer <= 22'(item_layer) * 22'(layer_step);
      prod_off   <= 25'(item_offset) * $signed({9'b0, offset_step});
    end
    if (cmd.sum) begin
      item_prio <= $signed({10'b0, prod_layer}) + 32'(prod_off) + 32'(item_adjust);
    end
    if (cmd.drain_start) begin
      remaining <= count;
    end else if (cmd.rotate) begin
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_proc <= '0;
      count    <= '0;
    end else if (cmd.clear) begin
      cur_proc <= item_process;
      count    <= '0;
    end else if (cmd.insert) begin
      count <= count + 1'b1;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int NXT = (i + 1) % CAPACITY;
    localparam int PRV = (i > 0) ? i - 1 : 0;

    assign lower[i] = (CW'(i) < count) && (cell_prio[i] < item_prio);

    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (i > 0 && lower[PRV]) begin
          cell_tag[i]  <= cell_tag[PRV];
          cell_prio[i] <= cell_prio[PRV];
        end else if (lower[i] || CW'(i) == count) begin
          cell_tag[i]  <= item_tag;
          cell_prio[i] <= item_prio;
        end
      end else if (cmd.rotate) begin
        if (CW'(i) == count_m1) begin
          cell_tag[i]  <= cell_tag[0];
          cell_prio[i] <= cell_prio[0];
        end else begin
          cell_tag[i]  <= cell_tag[NXT];
          cell_prio[i] <= cell_prio[NXT];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= cmd.status;
      out_last   <= cmd.last;
      case (cmd.prio_sel)
        PSEL_ITEM: begin
          out_tag  <= '0;
          out_prio <= item_prio;
        end
        PSEL_CELL: begin
          out_tag  <= cell_tag[0];
          out_prio <= cell_prio[0];
        end
        default: begin
          out_tag  <= '0;
          out_prio <= '0;
        end
      endcase
    end
  end

  assign stat.action      = action_t'(item_action);
  assign stat.layer_valid = item_valid;
  assign stat.proc_match  = (item_process == cur_proc);
  assign stat.full        = (count == CW'(CAPACITY));
  assign stat.empty       = (count == '0);
  assign stat.drain_last  = (remaining == CW'(1));
  assign stat.can_load    = !m_tvalid || m_tready;

endmodule

FILE: rtl/core/stable_priority_sorted_insert_list_top.sv
// Sorted registration list with descending priority order.
// Input words (s_*): tuser carries the action (begin, register, drain);
// tdata carries the item fields. Output words (m_*): tuser is the status,
// tdata holds tag and priority, tlast marks the final word of an item.
// Configuration: APB, layer_step at 0x0, offset_step at 0x4, pready tied high.
// Paths from the accepted word to the output word:
//   begin, skipped register, empty drain, unused action: decode, then emit.
//   register (insert or full drop): decode, multiply, sum and parallel
//   insert into the sorted cell row, then emit.
//   drain: decode, then one word per cycle while m_tready does not stall;
//   the row rotates once per word and is unchanged after.
// One item is in flight at a time; s_tready rises the cycle after the item's
// last word is loaded into the output register, so it may already be taken
// while that word still waits. A stalled m_tready holds the word and pauses
// the drain. Reset empties the list, sets process 0 and the step defaults.
module stable_priority_sorted_insert_list_top #(
  parameter int CAPACITY = 32,
  parameter int TAG_BITS = 10
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // process, tag, layer_valid, layer, offset, adjust
  input  logic [((TAG_BITS + 34 + 7) / 8) * 8 - 1:0] s_tdata,
  // action
  input  logic [1:0]                              s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // out_tag, out_priority
  output logic [((TAG_BITS + 32 + 7) / 8) * 8 - 1:0] m_tdata,
  // status
  output logic [2:0]                              m_tuser,
  output logic                                    m_tlast,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [2:0]                              paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import spsil_pkg::*;

  localparam int OW = ((TAG_BITS + 32 + 7) / 8) * 8;

  logic [STEP_BITS-1:0]        layer_step;
  logic [STEP_BITS-1:0]        offset_step;
  dp_cmd_t                     cmd;
  dp_stat_t                    stat;
  status_t                     out_status;
  logic [TAG_BITS-1:0]         out_tag;
  logic signed [PRIO_BITS-1:0] out_prio;

  assign pready = 1'b1;
  assign prdata = {16'b0, paddr[2] ? offset_step : layer_step};

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_step  <= 16'd1000;
      offset_step <= 16'd100;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        offset_step <= pwdata[15:0];
      end else begin
        layer_step <= pwdata[15:0];
      end
    end
  end

  spsil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spsil_dp #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (s_tuser),
    .in_process     (s_tdata[2:0]),
    .in_tag         (s_tdata[3 +: TAG_BITS]),
    .in_layer_valid (s_tdata[TAG_BITS + 3]),
    .in_layer       (s_tdata[TAG_BITS + 4 +: 6]),
    .in_offset      (s_tdata[TAG_BITS + 10 +: 8]),
    .in_adjust      (s_tdata[TAG_BITS + 18 +: 16]),
    .layer_step     (layer_step),
    .offset_step    (offset_step),
    .m_tready       (m_tready),
    .m_tvalid       (m_tvalid),
    .out_status     (out_status),
    .out_tag        (out_tag),
    .out_prio       (out_prio),
    .out_last       (m_tlast)
  );

  assign m_tdata = OW'({out_prio, out_tag});
  assign m_tuser = out_status;

endmodule

FILE: rtl/core/spsil_checker.sv
module spsil_checker #(
  parameter int TAG_BITS = 10
) (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    m_tvalid,
  input logic                                    m_tready,
  input logic [((TAG_BITS + 32 + 7) / 8) * 8 - 1:0] m_tdata,
  input logic [2:0]                              m_tuser,
  input logic                                    m_tlast
);
  import spsil_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STAT_ENTRY |-> m_tlast && m_tdata[TAG_BITS-1:0] == '0)
    else $error("non-entry word not a single last word with zero tag");

  a_zero_prio: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STAT_OTHER || m_tuser == STAT_INVALID
      || m_tuser == STAT_EMPTY) |-> m_tdata[TAG_BITS +: 32] == '0)
    else $error("skipped or empty word carries a priority");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind stable_priority_sorted_insert_list_top spsil_checker #(
  .TAG_BITS (TAG_BITS)
) u_spsil_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
